[design/wcs_pkg.sv]
// shared codes, field widths and chain link type for the weighted cdf sampler
// no dependencies
`default_nettype none

package wcs_pkg;

    localparam int REQ_W    = 2;
    localparam int DATA_W   = 16;
    localparam int OUT_IDX_W = 5;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic valid;
        logic found;
    } link_ctl_t;

endpackage

`default_nettype wire

[design/wcs_cell.sv]
// one table entry of the search chain: holds a prefix sum and checks the passing item
// depends on wcs_pkg
`default_nettype none

module wcs_cell #(
    parameter int IDX     = 0,
    parameter int IDX_W   = 4,
    parameter int CNT_W   = 5,
    parameter int TOTAL_W = 20
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    wr_en,
    input  wire  [TOTAL_W-1:0]     wr_data,
    input  wire  [CNT_W-1:0]       count,
    input  wcs_pkg::link_ctl_t     ctl_in,
    input  wire  [TOTAL_W-1:0]     u_in,
    input  wire  [IDX_W-1:0]       idx_in,
    output wcs_pkg::link_ctl_t     ctl_out,
    output logic [TOTAL_W-1:0]     u_out,
    output logic [IDX_W-1:0]       idx_out
);

    logic [TOTAL_W-1:0]  prefix_reg;
    wcs_pkg::link_ctl_t  ctl_reg, ctl_next;
    logic [TOTAL_W-1:0]  u_reg;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                in_range;
    logic                hit;

    assign in_range = CNT_W'(IDX) < count;
    assign hit      = ctl_in.valid & ~ctl_in.found & in_range & (u_in < prefix_reg);

    always_comb begin
        ctl_next.valid = ctl_in.valid;
        ctl_next.found = ctl_in.found | hit;
        idx_next       = idx_in;
        if (ctl_in.valid && !ctl_in.found && in_range) begin
            idx_next = IDX_W'(IDX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        u_reg   <= u_in;
        idx_reg <= idx_next;
        if (wr_en && count == CNT_W'(IDX)) begin
            prefix_reg <= wr_data;
        end
    end

    assign ctl_out = ctl_reg;
    assign u_out   = u_reg;
    assign idx_out = idx_reg;

endmodule

`default_nettype wire

[design/weighted_cdf_sampler_top.sv]
// weighted cdf sampler top level: request control, scaling multiplier, chain of table cells
// depends on wcs_pkg and wcs_cell
`default_nettype none

// Weighted-choice table of up to MAX_ENTRIES entries. Each cell of a chain holds the
// prefix sum of one entry. Clear (s_tuser 0) empties the table, append (1) adds the
// weight in s_tdata[15:0] and answers with the new entry count or a full status, and
// sample (2) scales s_tdata[31:16]/65536 by the total weight and returns the first
// entry whose prefix sum exceeds it (the last entry if none does). Clear, append, a
// sample on an empty table and the unused code go from accept straight to the done
// state; any other sample first runs the search, where the scaled value walks the
// cell chain one cell per cycle. One item is in work at a time; the result register
// lets the next item enter while a result waits on m_tready.
module weighted_cdf_sampler_top #(
    parameter int MAX_ENTRIES = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // weight [15:0], draw [31:16]
    input  wire  [1:0]  s_tuser,   // req_type [1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // chosen_index [4:0], zero [7:5]
    output logic [1:0]  m_tuser    // status [1:0]
);

    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int TOTAL_W = WEIGHT_BITS + $clog2(MAX_ENTRIES);
    localparam int PROD_W  = wcs_pkg::DATA_W + TOTAL_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_DONE   = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [TOTAL_W-1:0]          total_reg, total_next;
    logic [PROD_W-1:0]           prod_reg;
    logic                        launch_reg;
    logic [wcs_pkg::OUT_IDX_W-1:0] res_idx_reg, res_idx_next;
    logic [wcs_pkg::STATUS_W-1:0]  res_st_reg, res_st_next;
    logic                        m_valid_reg;
    logic [wcs_pkg::OUT_IDX_W-1:0] m_idx_reg;
    logic [wcs_pkg::STATUS_W-1:0]  m_st_reg;

    logic [wcs_pkg::REQ_W-1:0]   req_type;
    logic [wcs_pkg::DATA_W-1:0]  weight;
    logic [wcs_pkg::DATA_W-1:0]  draw;
    logic [47:0]                 weight_wide;
    logic [WEIGHT_BITS-1:0]      weight_eff;
    logic                        accept;
    logic                        wr_en;
    logic                        launch_next;
    logic                        out_free;
    logic [31:0]                 count_wide;
    logic [31:0]                 tail_idx_wide;

    wcs_pkg::link_ctl_t          ctl_link [0:MAX_ENTRIES];
    logic [TOTAL_W-1:0]          u_link   [0:MAX_ENTRIES];
    logic [IDX_W-1:0]            idx_link [0:MAX_ENTRIES];

    assign req_type    = s_tuser;
    assign weight      = s_tdata[15:0];
    assign draw        = s_tdata[31:16];
    assign weight_wide = 48'(weight);
    assign weight_eff  = weight_wide[WEIGHT_BITS-1:0];

    assign s_tready      = (state_reg == S_IDLE);
    assign accept        = s_tvalid & s_tready;
    assign out_free      = ~m_valid_reg | m_tready;
    assign count_wide    = 32'(count_reg);
    assign tail_idx_wide = 32'(idx_link[MAX_ENTRIES]);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        res_idx_next = res_idx_reg;
        res_st_next  = res_st_reg;
        wr_en        = 1'b0;
        launch_next  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next   = S_DONE;
                    res_idx_next = count_wide[wcs_pkg::OUT_IDX_W-1:0];
                    res_st_next  = wcs_pkg::ST_OK;
                    case (req_type)
                        wcs_pkg::REQ_CLEAR: begin
                            count_next   = '0;
                            total_next   = '0;
                            res_idx_next = '0;
                        end
                        wcs_pkg::REQ_APPEND: begin
                            if (count_reg == CNT_W'(MAX_ENTRIES)) begin
                                res_st_next = wcs_pkg::ST_FULL;
                            end else begin
                                wr_en        = 1'b1;
                                total_next   = total_reg + TOTAL_W'(weight_eff);
                                count_next   = count_reg + CNT_W'(1);
                                res_idx_next = wcs_pkg::OUT_IDX_W'(count_wide + 32'd1);
                            end
                        end
                        wcs_pkg::REQ_SAMPLE: begin
                            if (count_reg == '0) begin
                                res_idx_next = '0;
                                res_st_next  = wcs_pkg::ST_EMPTY;
                            end else begin
                                state_next  = S_SEARCH;
                                launch_next = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (ctl_link[MAX_ENTRIES].valid) begin
                    state_next   = S_DONE;
                    res_idx_next = tail_idx_wide[wcs_pkg::OUT_IDX_W-1:0];
                    res_st_next  = wcs_pkg::ST_OK;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            launch_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            launch_reg <= launch_next;
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_idx_reg <= res_idx_next;
        res_st_reg  <= res_st_next;
        if (accept) begin
            prod_reg <= PROD_W'(draw) * PROD_W'(total_reg);
        end
        if (state_reg == S_DONE && out_free) begin
            m_idx_reg <= res_idx_reg;
            m_st_reg  <= res_st_reg;
        end
    end

    assign ctl_link[0].valid = launch_reg;
    assign ctl_link[0].found = 1'b0;
    assign u_link[0]         = prod_reg[wcs_pkg::DATA_W +: TOTAL_W];
    assign idx_link[0]       = '0;

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        wcs_cell #(
            .IDX     (i),
            .IDX_W   (IDX_W),
            .CNT_W   (CNT_W),
            .TOTAL_W (TOTAL_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr_en   (wr_en),
            .wr_data (total_next),
            .count   (count_reg),
            .ctl_in  (ctl_link[i]),
            .u_in    (u_link[i]),
            .idx_in  (idx_link[i]),
            .ctl_out (ctl_link[i+1]),
            .u_out   (u_link[i+1]),
            .idx_out (idx_link[i+1])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_idx_reg};
    assign m_tuser  = m_st_reg;

    a_launch_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        launch_reg |-> (count_reg != '0 && state_reg == S_SEARCH))
        else $error("search launched on an empty table");

    a_tail_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_link[MAX_ENTRIES].valid |-> state_reg == S_SEARCH)
        else $error("chain result outside search");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_search_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEARCH && $past(state_reg) == S_SEARCH) |->
            ($stable(count_reg) && $stable(total_reg)))
        else $error("table changed during search");

endmodule

`default_nettype wire
